@@ sv/eulxyz_pkg.sv @@
// ----------------------------------------------------------------------------
// eulxyz_pkg
// Shared constants for the XYZ Euler angle-rate transform: sine polynomial
// coefficients in Q30, default widths and the reset threshold.
// ----------------------------------------------------------------------------
`default_nettype none

package eulxyz_pkg;

    // default widths
    localparam int ANGLE_BITS_DEF = 16;
    localparam int VEC_BITS_DEF   = 32;

    // quarter-wave sine z*(A - z^2*(B - z^2*C)), coefficients in Q30
    localparam logic [30:0] SIN_A   = 31'd1686629713;
    localparam logic [29:0] SIN_B   = 30'd688904866;
    localparam logic [26:0] SIN_C   = 27'd76016977;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    // quarter turn of a 16 bit binary angle
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    // rounding half of a Q1.15 product
    localparam int Q15_HALF = 16384;

    // singularity threshold after reset, Q1.15 (about 1e-3)
    localparam logic [14:0] MIN_COS_RST = 15'd33;

endpackage

`default_nettype wire

@@ sv/euler_xyz_rate_transform.sv @@
// ----------------------------------------------------------------------------
// euler_xyz_rate_transform
// Converts between angular velocity and space-fixed XYZ Euler angle rates.
//
// Input words arrive on the s_ channel: the direction in s_tuser (1 = rates
// to angular velocity, 0 = angular velocity to rates), pitch, yaw and the
// three vector components in s_tdata. One result word leaves on the m_
// channel per input word, in order, with singular and saturated in m_tuser.
// The threshold on |cos(pitch)| is written through cfg_wr_en/cfg_wr_data.
// The depth is set by the bit-serial divider, one quotient bit per stage over
// VEC_BITS + 16 stages. Throughput is one word per cycle while the output
// is not stalled.
// All stages advance together while the output register is empty or being
// taken; when the receiver holds m_tready low on a valid output word, the
// whole pipeline stalls and s_tready falls, nothing is dropped or repeated.
// Reset clears every valid bit and loads the threshold with 33.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_xyz_rate_transform
    import eulxyz_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int VEC_BITS   = VEC_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // threshold register
    input  wire logic                      cfg_wr_en,
    input  wire logic [14:0]               cfg_wr_data,
    // input words
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // pitch_angle, yaw_angle, vec_x, vec_y, vec_z from bit 0 up
    input  wire logic [((2*ANGLE_BITS+3*VEC_BITS+7)/8)*8-1:0] s_tdata,
    // action
    input  wire logic [0:0]                s_tuser,
    // result words
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // res_x, res_y, res_z from bit 0 up
    output logic [((3*VEC_BITS+7)/8)*8-1:0] m_tdata,
    // singular, saturated from bit 0 up
    output logic [1:0]                     m_tuser
);

    localparam int AW    = ANGLE_BITS;
    localparam int VW    = VEC_BITS;
    localparam int OUT_W = ((3*VW+7)/8)*8;
    localparam int PW    = VW + 18;
    localparam int DW    = VW + 16;
    localparam int NST   = DW + 15;

    localparam logic signed [VW+1:0] SAT_HI = {3'b000, {(VW-1){1'b1}}};
    localparam logic signed [VW+1:0] SAT_LO = {3'b111, {(VW-1){1'b0}}};
    localparam logic [DW-1:0]        Q_LIM  = DW'(1) << (VW-1);

    typedef struct packed {
        logic                 act;
        logic signed [VW-1:0] a;
        logic signed [VW-1:0] b;
        logic signed [VW-1:0] c;
    } front_t;

    typedef struct packed {
        logic                 act;
        logic                 sing;
        logic signed [VW-1:0] r0f;
        logic signed [VW-1:0] r1f;
        logic signed [VW-1:0] r2f;
        logic                 flag_f;
        logic signed [VW-1:0] r1i;
        logic                 flag_i;
        logic signed [16:0]   sp;
        logic signed [VW-1:0] c;
        logic                 nsgn;
    } side_t;

    // Q1.15 factor product rounded half away from zero
    function automatic logic signed [VW:0] rnd_q15(input logic signed [PW-1:0] p);
        logic [PW-1:0] m;
        logic [PW-1:0] r;
        m = p[PW-1] ? PW'(-p) : PW'(p);
        r = (m + PW'(Q15_HALF)) >> 15;
        return p[PW-1] ? -$signed(r[VW:0]) : $signed(r[VW:0]);
    endfunction

    // clamp to the vector range, flag in the top bit
    function automatic logic [VW:0] sat_v(input logic signed [VW+1:0] v);
        if (v > SAT_HI) begin
            return {1'b1, SAT_HI[VW-1:0]};
        end else if (v < SAT_LO) begin
            return {1'b1, SAT_LO[VW-1:0]};
        end
        return {1'b0, v[VW-1:0]};
    endfunction

    logic            adv;
    logic [NST-1:0]  vld_reg;
    logic [14:0]     min_cos_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_cos_reg <= MIN_COS_RST;
        end else if (cfg_wr_en) begin
            min_cos_reg <= cfg_wr_data;
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid && s_tready};
        end
    end

    // angle to 16 bit binary angle
    logic [15:0] pa16;
    logic [15:0] ya16;
    generate
        if (AW >= 16) begin : g_ang_trunc
            assign pa16 = s_tdata[AW-1 -: 16];
            assign ya16 = s_tdata[2*AW-1 -: 16];
        end else begin : g_ang_ext
            assign pa16 = {s_tdata[AW-1:0], {(16-AW){1'b0}}};
            assign ya16 = {s_tdata[2*AW-1:AW], {(16-AW){1'b0}}};
        end
    endgenerate

    // lane angles: sin pitch, cos pitch, sin yaw, cos yaw
    logic [15:0] ang [4];
    logic [14:0] xq  [4];
    always_comb begin
        ang[0] = pa16;
        ang[1] = pa16 + QUARTER_TURN;
        ang[2] = ya16;
        ang[3] = ya16 + QUARTER_TURN;
        for (int k = 0; k < 4; k++) begin
            xq[k] = ang[k][14] ? 15'(15'd16384 - {1'b0, ang[k][13:0]})
                               : {1'b0, ang[k][13:0]};
        end
    end

    // front side data along the sine stages
    front_t fr_reg [1:6];
    always_ff @(posedge aclk) begin
        if (adv) begin
            fr_reg[1] <= '{act: s_tuser[0],
                           a:   s_tdata[2*AW +: VW],
                           b:   s_tdata[2*AW+VW +: VW],
                           c:   s_tdata[2*AW+2*VW +: VW]};
            for (int i = 2; i <= 6; i++) begin
                fr_reg[i] <= fr_reg[i-1];
            end
        end
    end

    // sine lanes, at most one multiplier per stage
    logic [14:0]        x1_reg  [4];
    logic [14:0]        x2_reg  [4];
    logic [14:0]        x3_reg  [4];
    logic [14:0]        x4_reg  [4];
    logic               neg1_reg [4];
    logic               neg2_reg [4];
    logic               neg3_reg [4];
    logic               neg4_reg [4];
    logic               neg5_reg [4];
    logic [30:0]        z2_reg  [4];
    logic [30:0]        z2b_reg [4];
    logic [29:0]        in_reg  [4];
    logic [30:0]        t_reg   [4];
    logic [30:0]        s_reg   [4];
    logic signed [16:0] trig_reg [4];

    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic [29:0] sq;
        logic [57:0] pc;
        logic [60:0] pm;
        logic [45:0] ps;
        logic [31:0] sr;
        logic [31:0] rr;

        always_comb begin
            sq = x1_reg[k] * x1_reg[k];
            pc = z2_reg[k] * SIN_C;
            pm = z2b_reg[k] * in_reg[k];
            ps = x4_reg[k] * t_reg[k];
            sr = ps[45:14];
            rr = {1'b0, s_reg[k]} + 32'(Q15_HALF);
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                x1_reg[k]   <= xq[k];
                neg1_reg[k] <= ang[k][15];
                z2_reg[k]   <= {sq[28:0], 2'b00};
                x2_reg[k]   <= x1_reg[k];
                neg2_reg[k] <= neg1_reg[k];
                z2b_reg[k]  <= z2_reg[k];
                in_reg[k]   <= SIN_B - {2'b00, pc[57:30]};
                x3_reg[k]   <= x2_reg[k];
                neg3_reg[k] <= neg2_reg[k];
                t_reg[k]    <= SIN_A - pm[60:30];
                x4_reg[k]   <= x3_reg[k];
                neg4_reg[k] <= neg3_reg[k];
                s_reg[k]    <= (sr > {1'b0, Q30_ONE}) ? Q30_ONE : sr[30:0];
                neg5_reg[k] <= neg4_reg[k];
                trig_reg[k] <= neg5_reg[k] ? -$signed({1'b0, rr[30:15]})
                                           : $signed({1'b0, rr[30:15]});
            end
        end
    end

    // stage 7: trig by vector products
    logic signed [PW-1:0] prod_reg [6];
    logic                 act7_reg, sing7_reg;
    logic [15:0]          cpm7_reg;
    logic signed [VW-1:0] c7_reg;
    logic signed [16:0]   sp7_reg, sy7_reg, cy7_reg;
    logic [15:0]          cp_mag;

    assign cp_mag = trig_reg[1][16] ? 16'(-trig_reg[1]) : 16'(trig_reg[1]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg[0] <= trig_reg[1] * fr_reg[6].a;   // cp*a
            prod_reg[1] <= trig_reg[2] * fr_reg[6].b;   // sy*b
            prod_reg[2] <= trig_reg[0] * fr_reg[6].a;   // sp*a
            prod_reg[3] <= trig_reg[3] * fr_reg[6].b;   // cy*b
            prod_reg[4] <= trig_reg[3] * fr_reg[6].a;   // cy*a
            prod_reg[5] <= trig_reg[2] * fr_reg[6].a;   // sy*a
            act7_reg    <= fr_reg[6].act;
            sing7_reg   <= !fr_reg[6].act && (cp_mag <= {1'b0, min_cos_reg});
            cpm7_reg    <= cp_mag;
            c7_reg      <= fr_reg[6].c;
            sp7_reg     <= trig_reg[0];
            sy7_reg     <= trig_reg[2];
            cy7_reg     <= trig_reg[3];
        end
    end

    // stage 8: rounding
    logic signed [VW:0]   r8_reg [6];
    logic                 act8_reg, sing8_reg;
    logic [15:0]          cpm8_reg;
    logic signed [VW-1:0] c8_reg;
    logic signed [16:0]   sp8_reg, sy8_reg, cy8_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 6; i++) begin
                r8_reg[i] <= rnd_q15(prod_reg[i]);
            end
            act8_reg  <= act7_reg;
            sing8_reg <= sing7_reg;
            cpm8_reg  <= cpm7_reg;
            c8_reg    <= c7_reg;
            sp8_reg   <= sp7_reg;
            sy8_reg   <= sy7_reg;
            cy8_reg   <= cy7_reg;
        end
    end

    // stage 9: second forward products, inverse sums
    logic signed [PW-1:0] fp0_reg, fp1_reg;
    logic signed [VW+1:0] num9_reg, r1i9_reg, r2f9_reg;
    logic signed [VW:0]   sb9_reg, cyb9_reg;
    logic                 act9_reg, sing9_reg;
    logic [15:0]          cpm9_reg;
    logic signed [16:0]   sp9_reg;
    logic signed [VW-1:0] c9_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            fp0_reg   <= cy8_reg * r8_reg[0];
            fp1_reg   <= sy8_reg * r8_reg[0];
            num9_reg  <= r8_reg[4] + r8_reg[1];
            r1i9_reg  <= r8_reg[3] - r8_reg[5];
            r2f9_reg  <= c8_reg - r8_reg[2];
            sb9_reg   <= r8_reg[1];
            cyb9_reg  <= r8_reg[3];
            act9_reg  <= act8_reg;
            sing9_reg <= sing8_reg;
            cpm9_reg  <= cpm8_reg;
            sp9_reg   <= sp8_reg;
            c9_reg    <= c8_reg;
        end
    end

    // stage 10: forward rounding, dividend set-up
    logic signed [VW:0]   fa10_reg, fb10_reg, sb10_reg, cyb10_reg;
    logic [VW:0]          r1i10_reg, r2f10_reg;
    logic                 nsgn10_reg;
    logic [DW-1:0]        dvd10_reg;
    logic                 act10_reg, sing10_reg;
    logic [15:0]          cpm10_reg;
    logic signed [16:0]   sp10_reg;
    logic signed [VW-1:0] c10_reg;
    logic [VW+1:0]        num_mag;

    assign num_mag = num9_reg[VW+1] ? (VW+2)'(-num9_reg) : (VW+2)'(num9_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            fa10_reg   <= rnd_q15(fp0_reg);
            fb10_reg   <= rnd_q15(fp1_reg);
            sb10_reg   <= sb9_reg;
            cyb10_reg  <= cyb9_reg;
            r1i10_reg  <= sat_v(r1i9_reg);
            r2f10_reg  <= sat_v(r2f9_reg);
            nsgn10_reg <= num9_reg[VW+1];
            dvd10_reg  <= {num_mag[VW:0], 15'd0} + DW'(cpm9_reg >> 1);
            act10_reg  <= act9_reg;
            sing10_reg <= sing9_reg;
            cpm10_reg  <= cpm9_reg;
            sp10_reg   <= sp9_reg;
            c10_reg    <= c9_reg;
        end
    end

    // stage 11: forward results final, divider load
    side_t           side_reg [DW+1];
    logic [DW-1:0]   dq_reg   [DW+1];
    logic [14:0]     rem_reg  [DW+1];
    logic [15:0]     dvs_reg  [DW+1];
    logic signed [VW+1:0] d0_sum, d1_sum;
    logic [VW:0]     r0f_sat, r1f_sat;

    always_comb begin
        d0_sum  = fa10_reg - sb10_reg;
        d1_sum  = fb10_reg + cyb10_reg;
        r0f_sat = sat_v(d0_sum);
        r1f_sat = sat_v(d1_sum);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= '{act:    act10_reg,
                             sing:   sing10_reg,
                             r0f:    r0f_sat[VW-1:0],
                             r1f:    r1f_sat[VW-1:0],
                             r2f:    r2f10_reg[VW-1:0],
                             flag_f: r0f_sat[VW] | r1f_sat[VW] | r2f10_reg[VW],
                             r1i:    r1i10_reg[VW-1:0],
                             flag_i: r1i10_reg[VW],
                             sp:     sp10_reg,
                             c:      c10_reg,
                             nsgn:   nsgn10_reg};
            dq_reg[0]   <= dvd10_reg;
            rem_reg[0]  <= '0;
            dvs_reg[0]  <= cpm10_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 1; j <= DW; j++) begin : g_div
        logic [15:0] trial;
        logic        ge;
        logic [15:0] diff;

        always_comb begin
            trial = {rem_reg[j-1], dq_reg[j-1][DW-1]};
            ge    = trial >= dvs_reg[j-1];
            diff  = trial - dvs_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j]  <= ge ? diff[14:0] : trial[14:0];
                dq_reg[j]   <= {dq_reg[j-1][DW-2:0], ge};
                dvs_reg[j]  <= dvs_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // quotient clamp and sign
    logic signed [VW-1:0] tq_reg, tp_reg, tr_reg;
    logic                 tfq_reg, tfp_reg, tfr_reg;
    side_t                sdq_reg, sdp_reg, sdr_reg;
    logic [DW-1:0]        q_clamp;
    logic [VW-1:0]        q_mag;

    always_comb begin
        q_clamp = (dq_reg[DW] > Q_LIM) ? Q_LIM : dq_reg[DW];
        q_mag   = q_clamp[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (side_reg[DW].nsgn) begin
                tq_reg  <= -$signed(q_mag);
                tfq_reg <= 1'b0;
            end else if (q_clamp >= Q_LIM) begin
                tq_reg  <= SAT_HI[VW-1:0];
                tfq_reg <= 1'b1;
            end else begin
                tq_reg  <= $signed(q_mag);
                tfq_reg <= 1'b0;
            end
            sdq_reg <= side_reg[DW];
        end
    end

    // sp * t, then rounding
    logic signed [PW-1:0] ptp_reg;
    logic signed [VW:0]   rtr_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ptp_reg <= sdq_reg.sp * tq_reg;
            tp_reg  <= tq_reg;
            tfp_reg <= tfq_reg;
            sdp_reg <= sdq_reg;
            rtr_reg <= rnd_q15(ptp_reg);
            tr_reg  <= tp_reg;
            tfr_reg <= tfp_reg;
            sdr_reg <= sdp_reg;
        end
    end

    // output register
    logic signed [VW+1:0] r2i_sum;
    logic [VW:0]          r2i_sat;
    logic [VW-1:0]        res_x_reg, res_y_reg, res_z_reg;
    logic                 sing_reg, satf_reg;

    always_comb begin
        r2i_sum = rtr_reg + sdr_reg.c;
        r2i_sat = sat_v(r2i_sum);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (sdr_reg.act) begin
                res_x_reg <= sdr_reg.r0f;
                res_y_reg <= sdr_reg.r1f;
                res_z_reg <= sdr_reg.r2f;
                sing_reg  <= 1'b0;
                satf_reg  <= sdr_reg.flag_f;
            end else if (sdr_reg.sing) begin
                res_x_reg <= '0;
                res_y_reg <= '0;
                res_z_reg <= '0;
                sing_reg  <= 1'b1;
                satf_reg  <= 1'b0;
            end else begin
                res_x_reg <= tr_reg;
                res_y_reg <= sdr_reg.r1i;
                res_z_reg <= r2i_sat[VW-1:0];
                sing_reg  <= 1'b0;
                satf_reg  <= tfr_reg | sdr_reg.flag_i | r2i_sat[VW];
            end
        end
    end

    assign m_tdata = OUT_W'({res_z_reg, res_y_reg, res_x_reg});
    assign m_tuser = {satf_reg, sing_reg};

endmodule

`default_nettype wire
